### hw/rtl/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types, character codes and helpers for the timestamp text validator.
// ----------------------------------------------------------------------------
package tsv_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_FIXED       = 3'd0,
    PH_FRAC_START  = 3'd1,
    PH_FRAC_DIGITS = 3'd2,
    PH_AFTER_Z     = 3'd3,
    PH_ZONE        = 3'd4
  } phase_e;

  // One input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } word_t;

  // Result handed from the step logic to the output register
  typedef struct packed {
    logic fire;
    logic valid_res;
  } result_t;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_Z     = 8'h5A;

  // Layout limits
  localparam logic [4:0] FIXED_LEN  = 5'd19;
  localparam logic [4:0] POS_MAX    = 5'd31;
  localparam logic [4:0] ZONE_DONE  = 5'd5;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] LEAP_DAYS  = 7'd29;

  // Days in a month, month given as 1..12
  function automatic logic [6:0] month_days(input logic [6:0] month);
    logic [6:0] days;
    case (month)
      7'd2:                      days = 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   days = 7'd30;
      default:                   days = 7'd31;
    endcase
    return days;
  endfunction

  // Two BCD digits as a number divisible by four: (2*tens + ones) mod 4 == 0
  function automatic logic bcd_div4(input logic [3:0] tens, input logic [3:0] ones);
    logic [1:0] low;
    low = {tens[0], 1'b0} + ones[1:0];
    return low == 2'd0;
  endfunction

  // Gregorian leap rule on four BCD year digits
  function automatic logic is_leap(input logic [15:0] year);
    logic lo_zero;
    lo_zero = (year[7:0] == 8'h00);
    return bcd_div4(year[7:4], year[3:0]) && (!lo_zero || bcd_div4(year[15:12], year[11:8]));
  endfunction

endpackage

### hw/rtl/tsv_in_reg.sv
// ----------------------------------------------------------------------------
// tsv_in_reg
// Input register: captures one text word and holds it until the step logic
// consumes it.
// ----------------------------------------------------------------------------
module tsv_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tsv_pkg::word_t word_i,
  input  logic          advance_i,
  output logic          word_valid_o,
  output tsv_pkg::word_t word_o
);
  import tsv_pkg::*;

  logic  valid_q, valid_d;
  word_t word_q;
  logic  accept;

  // Stall only while a held word cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

### hw/rtl/tsv_core.sv
// ----------------------------------------------------------------------------
// tsv_core
// Parser state and the per-byte check: one word is folded into the state in
// each cycle that step_i is high, and the last word yields a result.
// ----------------------------------------------------------------------------
module tsv_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  tsv_pkg::word_t   word_i,
  output tsv_pkg::result_t result_o
);
  import tsv_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic        failed_q, failed_d;
  logic [15:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [3:0]  day_tens_q, day_tens_d;
  logic [3:0]  pair_tens_q, pair_tens_d;

  logic [7:0]  c;
  logic        dig;
  logic [3:0]  d;
  logic [6:0]  pair_val;
  logic [6:0]  day_val;
  logic [6:0]  day_lim;
  logic [4:0]  zone_pos;
  logic        is_sign;

  assign c        = word_i.char_code;
  assign dig      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign d        = dig ? c[3:0] : 4'd0;
  assign pair_val = ({3'b000, pair_tens_q} * 7'd10) + {3'b000, d};
  assign day_val  = ({3'b000, day_tens_q} * 7'd10) + {3'b000, d};
  assign day_lim  = ((month_q == 7'd2) && is_leap(year_q)) ? LEAP_DAYS : month_days(month_q);
  assign zone_pos = (pos_q < POS_MAX) ? pos_q + 5'd1 : pos_q;
  assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_DASH);

  // Next state and result for the current word
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    failed_d    = failed_q;
    year_d      = year_q;
    month_d     = month_q;
    day_tens_d  = day_tens_q;
    pair_tens_d = pair_tens_q;
    result_o    = '0;

    case (phase_q)
      PH_FIXED: begin
        if (pos_q < FIXED_LEN) begin
          pos_d = pos_q + 5'd1;
          case (pos_q)
            5'd4, 5'd7: begin
              if (c != CHAR_DASH) failed_d = 1'b1;
            end
            5'd10: begin
              if (c != CHAR_T) failed_d = 1'b1;
            end
            5'd13, 5'd16: begin
              if (c != CHAR_COLON) failed_d = 1'b1;
            end
            5'd0, 5'd1, 5'd2, 5'd3: begin
              if (!dig) failed_d = 1'b1;
              year_d = {year_q[11:0], d};
            end
            5'd5: begin
              if (!dig) failed_d = 1'b1;
              month_d = {3'b000, d} * 7'd10;
            end
            5'd6: begin
              if (!dig) failed_d = 1'b1;
              month_d = month_q + {3'b000, d};
              if ((month_d < 7'd1) || (month_d > 7'd12)) failed_d = 1'b1;
            end
            5'd8: begin
              if (!dig) failed_d = 1'b1;
              day_tens_d = d;
            end
            5'd9: begin
              if (!dig) failed_d = 1'b1;
              if ((month_q < 7'd1) || (month_q > 7'd12)) begin
                failed_d = 1'b1;
              end else if ((day_val < 7'd1) || (day_val > day_lim)) begin
                failed_d = 1'b1;
              end
            end
            5'd11, 5'd14, 5'd17: begin
              if (!dig) failed_d = 1'b1;
              pair_tens_d = d;
            end
            5'd12: begin
              if (!dig || (pair_val > HOUR_MAX)) failed_d = 1'b1;
            end
            default: begin
              if (!dig || (pair_val > MINUTE_MAX)) failed_d = 1'b1;
            end
          endcase
        end else if (c == CHAR_DOT) begin
          phase_d = PH_FRAC_START;
        end else if (c == CHAR_Z) begin
          phase_d = PH_AFTER_Z;
        end else if (is_sign) begin
          phase_d = PH_ZONE;
          pos_d   = 5'd0;
        end else begin
          failed_d = 1'b1;
        end
      end
      PH_FRAC_START: begin
        if (dig) phase_d = PH_FRAC_DIGITS;
        else failed_d = 1'b1;
      end
      PH_FRAC_DIGITS: begin
        if (!dig) begin
          if (c == CHAR_Z) begin
            phase_d = PH_AFTER_Z;
          end else if (is_sign) begin
            phase_d = PH_ZONE;
            pos_d   = 5'd0;
          end else begin
            failed_d = 1'b1;
          end
        end
      end
      PH_ZONE: begin
        pos_d = zone_pos;
        case (zone_pos)
          5'd1, 5'd4: begin
            if (!dig) failed_d = 1'b1;
            pair_tens_d = d;
          end
          5'd2: begin
            if (!dig || (pair_val > HOUR_MAX)) failed_d = 1'b1;
          end
          5'd3: begin
            if (c != CHAR_COLON) failed_d = 1'b1;
          end
          5'd5: begin
            if (!dig || (pair_val > MINUTE_MAX)) failed_d = 1'b1;
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end
      default: begin
        failed_d = 1'b1;
      end
    endcase

    // Report on the last byte and start over
    if (word_i.last_char) begin
      result_o.fire      = step_i;
      result_o.valid_res = !failed_d &&
                           ((phase_d == PH_AFTER_Z) ||
                            ((phase_d == PH_ZONE) && (pos_d == ZONE_DONE)));
      phase_d     = PH_FIXED;
      pos_d       = 5'd0;
      failed_d    = 1'b0;
      year_d      = 16'd0;
      month_d     = 7'd0;
      day_tens_d  = 4'd0;
      pair_tens_d = 4'd0;
    end
  end

  // Advance parser state on each consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIXED;
      pos_q       <= 5'd0;
      failed_q    <= 1'b0;
      year_q      <= 16'd0;
      month_q     <= 7'd0;
      day_tens_q  <= 4'd0;
      pair_tens_q <= 4'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      failed_q    <= failed_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_tens_q  <= day_tens_d;
      pair_tens_q <= pair_tens_d;
    end
  end

endmodule

### hw/rtl/tsv_out_reg.sv
// ----------------------------------------------------------------------------
// tsv_out_reg
// Result register: holds one verdict word until the consumer takes it.
// ----------------------------------------------------------------------------
module tsv_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsv_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             valid_res_o,
  output logic             free_o
);
  import tsv_pkg::*;

  logic valid_q, valid_d;
  logic res_q;

  // Room for a new word when empty or when the held one leaves now
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.fire) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the verdict
  always_ff @(posedge clk_i) begin
    if (result_i.fire) begin
      res_q <= result_i.valid_res;
    end
  end

  assign out_valid_o = valid_q;
  assign valid_res_o = res_q;

endmodule

### hw/rtl/timestamp_text_validator_unit.sv
// ----------------------------------------------------------------------------
// timestamp_text_validator_unit
// Checks a timestamp string, one byte per word, and gives one verdict word
// on the last byte of each string.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------
//   in       sink       in_valid_i / in_stall_o   char_code_i, last_char_i
//   out      source     out_valid_o / out_stall_i valid_res_o
//
// One byte per cycle, sustained, while the verdict channel is not stalled. A
// byte waits in the input register, where the parser state is updated; the
// verdict is loaded into the output register as the last byte leaves it.
// Reset returns the parser to the start of a string and empties both
// registers. A stalled verdict holds only last bytes back; other bytes keep
// flowing through the parser.
// ----------------------------------------------------------------------------
module timestamp_text_validator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       valid_res_o
);
  import tsv_pkg::*;

  word_t   word_in;
  word_t   word_q;
  logic    word_valid;
  logic    advance;
  logic    out_free;
  result_t result;

  assign word_in.char_code = char_code_i;
  assign word_in.last_char = last_char_i;

  // Consume a held word unless its verdict has nowhere to go
  assign advance = word_valid && (!word_q.last_char || out_free);

  tsv_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .word_i       (word_in),
    .advance_i    (advance),
    .word_valid_o (word_valid),
    .word_o       (word_q)
  );

  tsv_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (word_q),
    .result_o (result)
  );

  tsv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .valid_res_o (valid_res_o),
    .free_o      (out_free)
  );

endmodule

### tb/sv/tsv_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_verdict_checker
// Watches both channels of the timestamp text validator, parses every
// accepted byte with an independent timestamp parser and compares each
// verdict word that leaves the block with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module tsv_verdict_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       valid_res_i,
  output int         fail_count_o,
  output int         pending_o
);
  import tsv_pkg::*;

  // Parser state, mirrors what the block has to keep per string
  phase_e      ph;
  logic [4:0]  pos;
  logic        failed;
  logic [15:0] year_bcd;
  logic [6:0]  month;
  logic [3:0]  day_tens;
  logic [3:0]  pair_tens;

  // Verdicts predicted but not yet seen on the output
  logic        verdict_q[$];
  int          mismatches;
  logic        want;

  // Longest day allowed in a month, Gregorian leap rule on the BCD year
  function automatic int days_allowed(input logic [6:0] m, input logic [15:0] y);
    int lo;
    int hi;
    logic leap;
    lo   = y[7:4] * 10 + y[3:0];
    hi   = y[15:12] * 10 + y[11:8];
    leap = (lo % 4 == 0) && (lo != 0 || hi % 4 == 0);
    case (m)
      7'd2:                    return leap ? 29 : 28;
      7'd4, 7'd6, 7'd9, 7'd11: return 30;
      default:                 return 31;
    endcase
  endfunction

  task automatic clear_parser();
    ph        = PH_FIXED;
    pos       = '0;
    failed    = 1'b0;
    year_bcd  = '0;
    month     = '0;
    day_tens  = '0;
    pair_tens = '0;
  endtask

  // Two-digit field: tens already held, fail if not a digit or above limit
  task automatic check_pair(input logic dig, input logic [3:0] d, input int lim);
    int value;
    value = pair_tens * 10 + d;
    if (!dig || value > lim) failed = 1'b1;
  endtask

  // Z ends the string body, a sign opens the offset
  task automatic take_zone_mark(input logic [7:0] c);
    if (c == CHAR_Z) begin
      ph = PH_AFTER_Z;
    end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
      ph  = PH_ZONE;
      pos = '0;
    end else begin
      failed = 1'b1;
    end
  endtask

  // Date and time part, YYYY-MM-DDTHH:MM:SS
  task automatic take_fixed(input logic [7:0] c, input logic dig, input logic [3:0] d);
    int day;
    case (pos)
      5'd4, 5'd7:   if (c != CHAR_DASH) failed = 1'b1;
      5'd10:        if (c != CHAR_T) failed = 1'b1;
      5'd13, 5'd16: if (c != CHAR_COLON) failed = 1'b1;
      default: begin
        if (!dig) failed = 1'b1;
        case (pos)
          5'd0, 5'd1, 5'd2, 5'd3: year_bcd = {year_bcd[11:0], d};
          5'd5: month = d * 7'd10;
          5'd6: begin
            month = month + d;
            if (month < 7'd1 || month > 7'd12) failed = 1'b1;
          end
          5'd8: day_tens = d;
          5'd9: begin
            day = day_tens * 10 + d;
            if (month < 7'd1 || month > 7'd12) failed = 1'b1;
            else if (day < 1 || day > days_allowed(month, year_bcd)) failed = 1'b1;
          end
          5'd11, 5'd14, 5'd17: pair_tens = d;
          5'd12: check_pair(dig, d, HOUR_MAX);
          default: check_pair(dig, d, MINUTE_MAX);
        endcase
      end
    endcase
    pos = pos + 5'd1;
  endtask

  // Advance the parser by one byte, predict a verdict on the last one
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic       dig;
    logic [3:0] d;
    dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d   = dig ? 4'(c - CHAR_ZERO) : 4'd0;
    case (ph)
      PH_FIXED: begin
        if (pos < FIXED_LEN) take_fixed(c, dig, d);
        else if (c == CHAR_DOT) ph = PH_FRAC_START;
        else take_zone_mark(c);
      end
      PH_FRAC_START: begin
        if (dig) ph = PH_FRAC_DIGITS;
        else failed = 1'b1;
      end
      PH_FRAC_DIGITS: begin
        if (!dig) take_zone_mark(c);
      end
      PH_ZONE: begin
        if (pos != POS_MAX) pos = pos + 5'd1;
        case (pos)
          5'd1, 5'd4: begin
            if (!dig) failed = 1'b1;
            pair_tens = d;
          end
          5'd2:    check_pair(dig, d, HOUR_MAX);
          5'd3:    if (c != CHAR_COLON) failed = 1'b1;
          5'd5:    check_pair(dig, d, MINUTE_MAX);
          default: failed = 1'b1;
        endcase
      end
      default: failed = 1'b1;
    endcase
    if (last) begin
      verdict_q.insert(verdict_q.size(),
                       !failed && (ph == PH_AFTER_Z || (ph == PH_ZONE && pos == ZONE_DONE)));
      clear_parser();
    end
  endtask

  // Check the output first: a verdict never leaves in the cycle its byte enters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      verdict_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict word with none expected, expected none, got %0b",
                   $time, valid_res_i);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (valid_res_i !== want) begin
            $display("%0t: valid_res mismatch, expected %0b, got %0b",
                     $time, want, valid_res_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(char_code_i, last_char_i);
      fail_count_o <= mismatches;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives timestamp strings into the validator, directed corner cases first,
// then random well-formed, damaged and noise strings under several idle and
// stall mixes, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module tb;
  import tsv_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 65;
  localparam int DRAIN_CYCLES = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       last_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       valid_res_o;

  int         fail_count;
  int         pending;
  int         src_idle_pct;
  int         sink_stall_pct;
  int         cycle_count;
  logic [7:0] text_q[$];

  timestamp_text_validator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o)
  );

  tsv_verdict_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .valid_res_i  (valid_res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the verdict channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // End the run if it hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Append one byte to the string being built
  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  // Hand one byte over, idling first at random; hold it until accepted
  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_word(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    load_text(s);
    send_text();
  endtask

  // Append a number 0..99 as two digits
  task automatic add_pair(input int v);
    logic [7:0] tens;
    logic [7:0] ones;
    tens = 8'(v / 10);
    ones = 8'(v % 10);
    add_byte(CHAR_ZERO + tens);
    add_byte(CHAR_ZERO + ones);
  endtask

  // Mostly inside lo..hi, now and then anywhere in 0..99
  function automatic int pick(input int lo, input int hi);
    if ($urandom_range(7) == 0) return $urandom_range(99);
    return $urandom_range(hi, lo);
  endfunction

  // Build a well-formed timestamp with random content
  task automatic build_timestamp();
    int year;
    int month;
    int digits;
    text_q.delete();
    case ($urandom_range(3))
      0:       year = $urandom_range(9999);
      1:       year = 100 * $urandom_range(99);
      2:       year = 4 * $urandom_range(2499);
      default: year = 1970 + $urandom_range(99);
    endcase
    add_pair(year / 100);
    add_pair(year % 100);
    add_byte(CHAR_DASH);
    month = ($urandom_range(3) == 0) ? 2 : pick(1, 12);
    add_pair(month);
    add_byte(CHAR_DASH);
    add_pair(($urandom_range(2) == 0) ? pick(28, 31) : pick(1, 31));
    add_byte(CHAR_T);
    add_pair(pick(0, 23));
    add_byte(CHAR_COLON);
    add_pair(pick(0, 59));
    add_byte(CHAR_COLON);
    add_pair(pick(0, 59));
    // fraction: none, short, long or empty
    case ($urandom_range(7))
      0, 1, 2: digits = -1;
      3, 4, 5: digits = $urandom_range(1, 6);
      6:       digits = $urandom_range(7, 40);
      default: digits = 0;
    endcase
    if (digits >= 0) begin
      add_byte(CHAR_DOT);
      repeat (digits) add_byte(CHAR_ZERO + 8'($urandom_range(9)));
    end
    // zone
    if ($urandom_range(2) == 0) begin
      add_byte(CHAR_Z);
    end else begin
      add_byte($urandom_range(1) ? CHAR_PLUS : CHAR_DASH);
      add_pair(pick(0, 23));
      add_byte(CHAR_COLON);
      add_pair(pick(0, 59));
    end
  endtask

  // One random string: noise, a damaged timestamp or a clean one
  task automatic random_string();
    int kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      text_q.delete();
      repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(255)));
    end else begin
      build_timestamp();
      case (kind)
        1: text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        2: begin
          kind = $urandom_range(1, text_q.size() - 1);
          while (text_q.size() > kind) void'(text_q.pop_back());
        end
        3: repeat ($urandom_range(1, 4))
             add_byte($urandom_range(1) ? CHAR_ZERO + 8'($urandom_range(9))
                                        : 8'($urandom_range(255)));
        default: ;
      endcase
    end
    send_text();
  endtask

  initial begin
    int phase_bytes;
    int idle_mix[4];
    int stall_mix[4];
    idle_mix  = '{0, 45, 0, 26};
    stall_mix = '{0, 0, 45, 26};
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    char_code_i <= '0;
    last_char_i <= 1'b0;
    out_stall_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases
    send_str("2024-02-29T23:59:59Z");
    send_str("2023-02-29T00:00:00Z");
    send_str("2000-02-29T12:30:45.5+05:30");
    send_str("1900-02-29T00:00:00Z");
    send_str("0000-01-01T00:00:00.0-23:59");
    send_str("9999-12-31T23:59:59-00:00");
    send_str("2021-04-31T10:00:00Z");
    send_str("2021-00-10T10:00:00Z");
    send_str("2021-13-10T10:00:00Z");
    send_str("2021-01-00T10:00:00Z");
    send_str("2021-01-01T24:00:00Z");
    send_str("2021-01-01T00:60:00Z");
    send_str("2021-01-01T00:00:60Z");
    send_str("2021-01-01T00:00:00+24:00");
    send_str("2021-01-01T00:00:00+00:60");
    send_str("2021-01-01T00:00:00+0100");
    send_str("2021-01-01T00:00:00.Z");
    send_str("2021-01-01T00:00:00.25");
    send_str("2021-01-01T00:00:00");
    send_str("7");
    send_str("2021-01-01T00:00:00Zx");
    send_str("2021-01-01T00:00:00+01:000");
    send_str("2021-01-01t00:00:00z");
    send_str("2021/01-01T00:00:00Z");
    send_str("2021-0a-01T00:00:00Z");
    // long fraction, then an offset that runs on past saturation
    text_q.delete();
    load_text("2021-06-15T08:09:10.");
    repeat (40) add_byte(CHAR_NINE);
    load_text("Z");
    send_text();
    text_q.delete();
    load_text("2021-06-15T08:09:10+01:00");
    repeat (35) add_byte(CHAR_ZERO);
    send_text();
    // byte extremes
    text_q = '{8'hFF, 8'h00};
    send_text();

    // Random strings under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_mix[p];
      sink_stall_pct = stall_mix[p];
      phase_bytes    = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_string();
        phase_bytes += text_q.size();
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding verdicts, then let the pipeline settle
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
